[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the character store.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check an implication on every rising clock edge outside reset.
`define CBP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define CBP_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define CBP_ASSERT(lbl, clk, rstn, prop, msg)
`define CBP_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[hw/rtl/cbp_pkg.sv]
`timescale 1ns / 1ps
// Types and codes of the character store with palindrome check.
// No dependencies; used by the top level.
package cbp_pkg;

    // operation codes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CHECK  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADINDEX = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_in;
        logic [5:0] position;
    } cbp_req_t;

    typedef struct packed {
        logic       is_palindrome;
        logic [6:0] fill_count;
        logic [7:0] read_char;
        logic [1:0] status;
    } cbp_rsp_t;

endpackage

[hw/rtl/cbp_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write one entry, register one read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/char_buffer_palindrome_check.sv]
`timescale 1ns / 1ps
// Character store with append, delete, read and palindrome check.
// Depends on cbp_pkg, cbp_ram and assert_macros.svh.
//
// Usage: one operation beat enters on req (valid/stall); exactly one result
// beat leaves on rsp (valid/stall). The store holds up to DEPTH bytes in two
// mirrored RAMs with registered reads; both are written together so the
// check can fetch both ends of a pair in the same cycle.
// Append writes one byte; rejected ops and a check on fewer than 2 bytes go
// straight to the result; read fetches one byte; delete at p moves each later
// byte one slot lower (one RAM read/write per moved byte); check with n bytes
// compares one pair per cycle, with an early out on the first mismatch.
// One item is worked at a time; req is stalled until the item is done, but a
// finished result waiting in the output register does not hold back the next
// request.
// Reset empties the store (fill count zero); RAM contents need no clearing.
// While rsp is stalled, the result holds and the next result waits inside.
module char_buffer_palindrome_check
    import cbp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  cbp_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output cbp_rsp_t rsp
);
    `include "assert_macros.svh"

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_CHECK,
        S_FINISH
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  src_reg, src_next;
    logic [AW-1:0]  lo_reg, lo_next;
    logic [AW-1:0]  hi_reg, hi_next;
    logic [AW-1:0]  wr_addr_reg, wr_addr_next;
    logic           pend_reg, pend_next;
    cbp_rsp_t       res_reg, res_next;
    cbp_rsp_t       rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [7:0]     wdata;
    logic [AW-1:0]  raddr_a;
    logic [7:0]     rd_a;
    logic [7:0]     rd_b;

    // low seven bits of a fill count
    function automatic logic [6:0] fill_of(input logic [CW-1:0] c);
        logic [CMPW-1:0] ext;
        ext = CMPW'(c);
        return ext[6:0];
    endfunction

    // two mirrored copies of the store, one read port each
    cbp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    cbp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (hi_reg),
        .rdata (rd_b)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // sequence one operation: decode, walk the RAM, finish
    always_comb
    begin
        logic [CMPW-1:0] pos_ext;
        logic [CMPW-1:0] cnt_ext;
        logic [CW-1:0]   cnt_inc;
        logic [CW-1:0]   cnt_dec;
        logic [CW-1:0]   src_dec;
        logic            rsp_free;
        logic            mism;

        pos_ext  = CMPW'(req.position);
        cnt_ext  = CMPW'(cnt_reg);
        cnt_inc  = cnt_reg + 1'b1;
        cnt_dec  = cnt_reg - 1'b1;
        src_dec  = src_reg - 1'b1;
        rsp_free = !rsp_valid_reg || !rsp_stall;
        mism     = pend_reg && (rd_a != rd_b);

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        src_next       = src_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        wr_addr_next   = wr_addr_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        we      = 1'b0;
        waddr   = wr_addr_reg;
        wdata   = rd_a;
        raddr_a = lo_reg;

        // drop a result beat once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next            = '0;
                    res_next.fill_count = fill_of(cnt_reg);
                    res_next.status     = ST_OK;
                    state_next          = S_FINISH;
                    unique case (req.mode)
                        MODE_APPEND:
                        begin
                            if (cnt_ext < CMPW'(DEPTH))
                            begin
                                we                  = 1'b1;
                                waddr               = cnt_reg[AW-1:0];
                                wdata               = req.char_in;
                                cnt_next            = cnt_inc;
                                res_next.fill_count = fill_of(cnt_inc);
                            end
                            else
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                src_next   = CW'(pos_ext + 1'b1);
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                res_next.status = ST_BADINDEX;
                            end
                        end
                        MODE_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                raddr_a    = pos_ext[AW-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next.status = ST_BADINDEX;
                            end
                        end
                        MODE_CHECK:
                        begin
                            if (cnt_ext < CMPW'(2))
                            begin
                                res_next.is_palindrome = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = cnt_dec[AW-1:0];
                                pend_next  = 1'b0;
                                state_next = S_CHECK;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_next.read_char = rd_a;
                state_next         = S_FINISH;
            end

            S_SHIFT:
            begin
                // write back the byte fetched last cycle, one slot lower
                if (pend_reg)
                begin
                    we = 1'b1;
                end
                if (src_reg < cnt_reg)
                begin
                    raddr_a      = src_reg[AW-1:0];
                    wr_addr_next = src_dec[AW-1:0];
                    src_next     = src_reg + 1'b1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    cnt_next            = cnt_dec;
                    res_next.fill_count = fill_of(cnt_dec);
                    pend_next           = 1'b0;
                    state_next          = S_FINISH;
                end
            end

            S_CHECK:
            begin
                // compare the pair fetched last cycle, fetch the next one
                if (mism)
                begin
                    res_next.is_palindrome = 1'b0;
                    pend_next              = 1'b0;
                    state_next             = S_FINISH;
                end
                else if (!(lo_reg < hi_reg))
                begin
                    res_next.is_palindrome = 1'b1;
                    pend_next              = 1'b0;
                    state_next             = S_FINISH;
                end
                else
                begin
                    lo_next   = lo_reg + 1'b1;
                    hi_next   = hi_reg - 1'b1;
                    pend_next = 1'b1;
                end
            end

            S_FINISH:
            begin
                // hand the result to the output register when it frees up
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state, count and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        wr_addr_reg <= wr_addr_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    `CBP_NEVER(a_cnt_bound, clk, rst_n, cnt_reg > CW'(DEPTH), "fill count above depth")
    `CBP_NEVER(a_no_write_in_check, clk, rst_n, (state_reg == S_CHECK) && we, "write during check")
    `CBP_ASSERT(a_shift_below_cnt, clk, rst_n, (state_reg == S_SHIFT) && we |-> (CW'(waddr) < cnt_reg), "shift write beyond fill")
    `CBP_ASSERT(a_finish_pushes, clk, rst_n, (state_reg == S_FINISH) && (!rsp_valid || !rsp_stall) |=> rsp_valid && (state_reg == S_IDLE), "finished result not presented")

endmodule
